>>> sv/alpe_pkg.sv
// ----------------------------------------------------------------------------
// alpe_pkg
// Shared types, constants and the brightness gain table of the LED encoder.
// ----------------------------------------------------------------------------
package alpe_pkg;

  // Field widths of the item channels.
  localparam int OP_W       = 2;
  localparam int LED_IDX_W  = 6;
  localparam int CHAN_W     = 8;
  localparam int COLOR_W    = 3 * CHAN_W;
  localparam int WORD_W     = 16;
  localparam int BRIGHT_W   = 6;
  localparam int GAIN_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Bits sent for one LED.
  localparam int BITS_PER_LED = COLOR_W;

  // Reciprocal of three in Q0.17; exact floor for dividends below 2^17.
  localparam logic [16:0] RECIP3_Q17 = 17'd43691;

  // Unity gain in Q1.16.
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd65536;

  // Register reset values.
  localparam logic [WORD_W-1:0]   PERIOD_RST  = 16'd104;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST  = 6'd45;
  localparam logic                SCALING_RST = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALING    = 2'd2;

  // Operation codes of an input item.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_SEND  = 2'd1,
    OP_GAP   = 2'd2
  } op_t;

  // The two compare words of a bit slot.
  typedef struct packed {
    logic [WORD_W-1:0] one_word;
    logic [WORD_W-1:0] zero_word;
  } word_pair_t;

  // Run handed to the emitter.
  typedef struct packed {
    logic                    is_gap;
    logic [BITS_PER_LED-1:0] bits;
  } emit_load_t;

  // Gain tan(angle) in Q1.16; angles above 45 degrees clamp to unity.
  function automatic logic [GAIN_W-1:0] gain_q16(input logic [BRIGHT_W-1:0] angle);
    logic [GAIN_W-1:0] g;
    case (angle)
      6'd0:  g = 17'd0;
      6'd1:  g = 17'd1144;
      6'd2:  g = 17'd2289;
      6'd3:  g = 17'd3435;
      6'd4:  g = 17'd4583;
      6'd5:  g = 17'd5734;
      6'd6:  g = 17'd6888;
      6'd7:  g = 17'd8047;
      6'd8:  g = 17'd9210;
      6'd9:  g = 17'd10380;
      6'd10: g = 17'd11556;
      6'd11: g = 17'd12739;
      6'd12: g = 17'd13930;
      6'd13: g = 17'd15130;
      6'd14: g = 17'd16340;
      6'd15: g = 17'd17560;
      6'd16: g = 17'd18792;
      6'd17: g = 17'd20036;
      6'd18: g = 17'd21294;
      6'd19: g = 17'd22566;
      6'd20: g = 17'd23853;
      6'd21: g = 17'd25157;
      6'd22: g = 17'd26478;
      6'd23: g = 17'd27818;
      6'd24: g = 17'd29179;
      6'd25: g = 17'd30560;
      6'd26: g = 17'd31964;
      6'd27: g = 17'd33392;
      6'd28: g = 17'd34846;
      6'd29: g = 17'd36327;
      6'd30: g = 17'd37837;
      6'd31: g = 17'd39378;
      6'd32: g = 17'd40951;
      6'd33: g = 17'd42560;
      6'd34: g = 17'd44205;
      6'd35: g = 17'd45889;
      6'd36: g = 17'd47615;
      6'd37: g = 17'd49385;
      6'd38: g = 17'd51202;
      6'd39: g = 17'd53070;
      6'd40: g = 17'd54991;
      6'd41: g = 17'd56970;
      6'd42: g = 17'd59009;
      6'd43: g = 17'd61113;
      6'd44: g = 17'd63287;
      default: g = GAIN_UNITY;
    endcase
    return g;
  endfunction

endpackage

>>> sv/alpe_if.sv
// ----------------------------------------------------------------------------
// alpe_if
// Valid/ready channels for input items and result items of the LED encoder.
// ----------------------------------------------------------------------------

// Input item channel.
interface alpe_in_if;
  logic                           valid;
  logic                           ready;
  logic [alpe_pkg::OP_W-1:0]      operation;
  logic [alpe_pkg::LED_IDX_W-1:0] led_index;
  logic [alpe_pkg::CHAN_W-1:0]    red;
  logic [alpe_pkg::CHAN_W-1:0]    green;
  logic [alpe_pkg::CHAN_W-1:0]    blue;

  modport source (output valid, operation, led_index, red, green, blue, input ready);
  modport sink   (input valid, operation, led_index, red, green, blue, output ready);
endinterface

// Result item channel.
interface alpe_out_if;
  logic                        valid;
  logic                        ready;
  logic [alpe_pkg::WORD_W-1:0] compare_value;
  logic                        last;

  modport source (output valid, compare_value, last, input ready);
  modport sink   (input valid, compare_value, last, output ready);
endinterface

>>> sv/addressable_led_pwm_encoder_core.sv
// ----------------------------------------------------------------------------
// addressable_led_pwm_encoder_core
// Stores LED colors and turns them into PWM compare words for an LED chain.
// ----------------------------------------------------------------------------
// Flow: a send or gap item is held in the lookup register and then loaded into the
// output shifter, whose first compare word is then valid on the output.
// Throughput: the output shifter gives one word per cycle while the output is ready;
// a send item gives one word for each color bit and a gap item RESET_SLOTS words. Input
// waits while a send or gap sits in the lookup register, which holds the next run while the shifter is busy.
// Reset: synchronous, active low; registers return to their defaults and per-entry
// valid flags clear at once, so every LED reads as black.
module addressable_led_pwm_encoder_core #(
  parameter int LED_COUNT   = 64,
  parameter int RESET_SLOTS = 50
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [alpe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [alpe_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  alpe_in_if.sink                            in_ch,
  alpe_out_if.source                         out_ch
);

  // Only indexes reachable by the index field need storage.
  localparam int IDX_SPAN    = 2 ** alpe_pkg::LED_IDX_W;
  localparam int STORE_DEPTH = (LED_COUNT < IDX_SPAN) ? LED_COUNT : IDX_SPAN;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [alpe_pkg::WORD_W-1:0]   pwm_period_r;
  logic [alpe_pkg::BRIGHT_W-1:0] brightness_r;
  logic                          scaling_r;

  logic                          in_fire;
  logic                          in_range;
  logic [ADDR_W-1:0]             in_addr;
  logic                          store_we;
  logic                          store_re;
  logic [alpe_pkg::COLOR_W-1:0]  store_rdata;
  logic [STORE_DEPTH-1:0]        valid_r;
  logic [STORE_DEPTH-1:0]        valid_nxt;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          s1_gap_r;
  logic                          s1_gap_nxt;
  logic                          s1_hit_r;
  logic                          s1_hit_nxt;

  logic [alpe_pkg::COLOR_W-1:0]  scaled_color;
  alpe_pkg::word_pair_t          words;
  alpe_pkg::emit_load_t          load;
  logic                          load_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_period_r <= alpe_pkg::PERIOD_RST;
      brightness_r <= alpe_pkg::BRIGHT_RST;
      scaling_r    <= alpe_pkg::SCALING_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        alpe_pkg::CFG_PWM_PERIOD: pwm_period_r <= cfg_wdata;
        alpe_pkg::CFG_BRIGHTNESS: brightness_r <= cfg_wdata[alpe_pkg::BRIGHT_W-1:0];
        alpe_pkg::CFG_SCALING:    scaling_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input stage accepts whenever the lookup register is free.
  assign in_ch.ready = !s1_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = 32'(in_ch.led_index) < LED_COUNT;
  assign in_addr     = ADDR_W'(in_ch.led_index);

  // Decode the item: writes go to the store, sends and gaps to the lookup stage.
  always_comb begin
    store_we     = 1'b0;
    store_re     = 1'b0;
    valid_nxt    = valid_r;
    s1_valid_nxt = s1_valid_r && !load_take;
    s1_gap_nxt   = s1_gap_r;
    s1_hit_nxt   = s1_hit_r;
    if (in_fire) begin
      case (alpe_pkg::op_t'(in_ch.operation))
        alpe_pkg::OP_WRITE: begin
          if (in_range) begin
            store_we           = 1'b1;
            valid_nxt[in_addr] = 1'b1;
          end
        end
        alpe_pkg::OP_SEND: begin
          store_re     = 1'b1;
          s1_valid_nxt = 1'b1;
          s1_gap_nxt   = 1'b0;
          s1_hit_nxt   = in_range && valid_r[in_addr];
        end
        alpe_pkg::OP_GAP: begin
          s1_valid_nxt = 1'b1;
          s1_gap_nxt   = 1'b1;
          s1_hit_nxt   = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
      s1_gap_r   <= 1'b0;
      s1_hit_r   <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      s1_valid_r <= s1_valid_nxt;
      s1_gap_r   <= s1_gap_nxt;
      s1_hit_r   <= s1_hit_nxt;
    end
  end

  // Color store, packed green, red, blue from the top byte down.
  alpe_ram #(
    .WIDTH (alpe_pkg::COLOR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (in_addr),
    .wdata ({in_ch.green, in_ch.red, in_ch.blue}),
    .re    (store_re),
    .raddr (in_addr),
    .rdata (store_rdata)
  );

  // Gain, compare words and color scaling.
  alpe_scale u_scale (
    .clk            (clk),
    .pwm_period     (pwm_period_r),
    .brightness     (brightness_r),
    .scaling_enable (scaling_r),
    .color_hit      (s1_hit_r),
    .color          (store_rdata),
    .scaled_color   (scaled_color),
    .words          (words)
  );

  assign load.is_gap = s1_gap_r;
  assign load.bits   = scaled_color;

  // Output shifter and result register.
  alpe_emitter #(
    .RESET_SLOTS (RESET_SLOTS)
  ) u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (s1_valid_r),
    .load       (load),
    .load_take  (load_take),
    .words      (words),
    .out_ch     (out_ch)
  );

endmodule

>>> sv/alpe_ram.sv
// ----------------------------------------------------------------------------
// alpe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module alpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/alpe_scale.sv
// ----------------------------------------------------------------------------
// alpe_scale
// Brightness gain and bit-slot compare words, and scaling of one LED color.
// ----------------------------------------------------------------------------
module alpe_scale (
  input  logic                             clk,
  input  logic [alpe_pkg::WORD_W-1:0]      pwm_period,
  input  logic [alpe_pkg::BRIGHT_W-1:0]    brightness,
  input  logic                             scaling_enable,
  input  logic                             color_hit,
  input  logic [alpe_pkg::COLOR_W-1:0]     color,
  output logic [alpe_pkg::COLOR_W-1:0]     scaled_color,
  output alpe_pkg::word_pair_t             words
);

  logic [alpe_pkg::GAIN_W-1:0] gain_r;
  logic [alpe_pkg::GAIN_W-1:0] gain_nxt;
  alpe_pkg::word_pair_t        words_r;
  alpe_pkg::word_pair_t        words_nxt;
  logic [32:0]                 zero_prod;
  logic [33:0]                 one_prod;
  logic [alpe_pkg::COLOR_W-1:0] color_in;

  // Gain follows the registers; disabled scaling is unity gain.
  always_comb begin
    if (scaling_enable) begin
      gain_nxt = alpe_pkg::gain_q16(brightness);
    end else begin
      gain_nxt = alpe_pkg::GAIN_UNITY;
    end
  end

  // Divide period and twice the period by three through the reciprocal.
  always_comb begin
    zero_prod = 33'(pwm_period) * 33'(alpe_pkg::RECIP3_Q17);
    one_prod  = 34'({pwm_period, 1'b0}) * 34'(alpe_pkg::RECIP3_Q17);
    words_nxt.zero_word = zero_prod[32:17];
    words_nxt.one_word  = one_prod[32:17];
  end

  always_ff @(posedge clk) begin
    gain_r  <= gain_nxt;
    words_r <= words_nxt;
  end

  assign words = words_r;

  // A missed or never-written LED reads as black.
  assign color_in = color_hit ? color : '0;

  // Scale each channel by the gain and keep the integer part.
  always_comb begin
    logic [alpe_pkg::CHAN_W+alpe_pkg::GAIN_W-1:0] prod;
    for (int c = 0; c < 3; c++) begin
      prod = (alpe_pkg::CHAN_W + alpe_pkg::GAIN_W)'(color_in[c*alpe_pkg::CHAN_W +: alpe_pkg::CHAN_W])
           * (alpe_pkg::CHAN_W + alpe_pkg::GAIN_W)'(gain_r);
      scaled_color[c*alpe_pkg::CHAN_W +: alpe_pkg::CHAN_W] = prod[16 +: alpe_pkg::CHAN_W];
    end
  end

endmodule

>>> sv/alpe_emitter.sv
// ----------------------------------------------------------------------------
// alpe_emitter
// Shifts a loaded run out as compare words, one item per cycle while the output is ready.
// ----------------------------------------------------------------------------
module alpe_emitter #(
  parameter int RESET_SLOTS = 50
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_valid,
  input  alpe_pkg::emit_load_t  load,
  output logic                  load_take,
  input  alpe_pkg::word_pair_t  words,
  alpe_out_if.source            out_ch
);

  localparam int RUN_MAX = (RESET_SLOTS > alpe_pkg::BITS_PER_LED) ? RESET_SLOTS
                                                                  : alpe_pkg::BITS_PER_LED;
  localparam int CNT_W   = $clog2(RUN_MAX);

  logic                              busy_r;
  logic                              busy_nxt;
  logic                              gap_r;
  logic                              gap_nxt;
  logic [CNT_W-1:0]                  cnt_r;
  logic [CNT_W-1:0]                  cnt_nxt;
  logic [alpe_pkg::BITS_PER_LED-1:0] shift_r;
  logic [alpe_pkg::BITS_PER_LED-1:0] shift_nxt;
  logic                              last_word;
  logic                              out_fire;

  assign last_word = (cnt_r == '0);
  assign out_fire  = busy_r && out_ch.ready;
  assign load_take = load_valid && (!busy_r || (out_fire && last_word));

  // Load a new run, step through the current one, or fall idle.
  always_comb begin
    busy_nxt  = busy_r;
    gap_nxt   = gap_r;
    cnt_nxt   = cnt_r;
    shift_nxt = shift_r;
    if (load_take) begin
      busy_nxt  = 1'b1;
      gap_nxt   = load.is_gap;
      shift_nxt = load.bits;
      if (load.is_gap) begin
        cnt_nxt = CNT_W'(RESET_SLOTS - 1);
      end else begin
        cnt_nxt = CNT_W'(alpe_pkg::BITS_PER_LED - 1);
      end
    end else if (out_fire) begin
      if (last_word) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt   = cnt_r - 1'b1;
        shift_nxt = {shift_r[alpe_pkg::BITS_PER_LED-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      gap_r  <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      gap_r  <= gap_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  // Gap slots carry zero; bit slots pick the word for the top bit.
  always_comb begin
    out_ch.valid = busy_r;
    out_ch.last  = last_word;
    if (gap_r) begin
      out_ch.compare_value = '0;
    end else if (shift_r[alpe_pkg::BITS_PER_LED-1]) begin
      out_ch.compare_value = words.one_word;
    end else begin
      out_ch.compare_value = words.zero_word;
    end
  end

endmodule
